// ===== src/sat_pkg.sv =====
`timescale 1ns / 1ps

package sat_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// ===== src/sorted_array_table.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_action, i_value, i_position
// out      | output    | o_out_valid / i_out_ready  | o_status, o_read_value,
//          |           |                            | o_entry_count
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_wdata (max_entries)
//
// Insert scans down through the entry store from the top entry, moving
// each entry at or above the new value up one place (one read and one
// shifted write per cycle).
// Reset: synchronous, active low; clears the count and the output valid,
// loads max_entries with 16. Entry storage is not cleared.
// Stalls: a result waits in the output register; the next transaction
// may be accepted meanwhile but completes only once the slot is free.
module sorted_array_table #(
    parameter int DEPTH = sat_pkg::DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transaction
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sat_pkg::ACTION_W-1:0]    i_action,
    input  logic [sat_pkg::VALUE_W-1:0]     i_value,
    input  logic [sat_pkg::POS_W-1:0]       i_position,
    // result transaction
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sat_pkg::STATUS_W-1:0]    o_status,
    output logic [sat_pkg::VALUE_W-1:0]     o_read_value,
    output logic [sat_pkg::COUNT_OUT_W-1:0] o_entry_count,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [sat_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // capacity limit; saturation at DEPTH is done in the sequencer
    logic [sat_pkg::CFG_W-1:0] r_max_entries;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [sat_pkg::VALUE_W-1:0] mem_wdata;
    logic [sat_pkg::VALUE_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= sat_pkg::MAX_ENTRIES_RESET;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    sat_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_max_entries (r_max_entries),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    sat_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== src/sat_mem.sv =====
`timescale 1ns / 1ps

// Entry store: one write port, one read port, registered read data.
module sat_mem #(
    parameter int DEPTH = sat_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  logic [sat_pkg::VALUE_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]    i_raddr,
    output logic [sat_pkg::VALUE_W-1:0] o_rdata
);

    logic [sat_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [sat_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sat_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer: walks the store one entry per cycle through a single
// compare unit, shifting entries as it goes. Holds count and result.
module sat_ctrl #(
    parameter int DEPTH = sat_pkg::DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sat_pkg::ACTION_W-1:0]   i_action,
    input  logic [sat_pkg::VALUE_W-1:0]    i_value,
    input  logic [sat_pkg::POS_W-1:0]      i_position,
    input  logic [sat_pkg::CFG_W-1:0]      i_max_entries,
    output logic                           o_mem_we,
    output logic [$clog2(DEPTH)-1:0]       o_mem_waddr,
    output logic [sat_pkg::VALUE_W-1:0]    o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]       o_mem_raddr,
    input  logic [sat_pkg::VALUE_W-1:0]    i_mem_rdata,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sat_pkg::STATUS_W-1:0]   o_status,
    output logic [sat_pkg::VALUE_W-1:0]    o_read_value,
    output logic [sat_pkg::COUNT_OUT_W-1:0] o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + sat_pkg::POS_W;
    localparam int KW = CW + sat_pkg::CFG_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS_CMP = 6'b000010,
        S_INS_PUT = 6'b000100,
        S_RM_MV   = 6'b001000,
        S_LK_WAIT = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_k, n_k;
    logic [sat_pkg::VALUE_W-1:0]     r_value, n_value;
    logic [sat_pkg::VALUE_W-1:0]     r_rd, n_rd;
    sat_pkg::t_status                r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    logic [sat_pkg::STATUS_W-1:0]    r_out_status, n_out_status;
    logic [sat_pkg::VALUE_W-1:0]     r_out_rd, n_out_rd;
    logic [sat_pkg::COUNT_OUT_W-1:0] r_out_cnt, n_out_cnt;

    logic [CW-1:0]  wr_idx, rd_idx;
    logic [PW-1:0]  pos_ext, pos1_ext, cnt_pos;
    logic [KW-1:0]  max_ext, cnt_ext;
    logic [CW:0]    k2_ext;
    logic           pos_ok, pos_has_next, full, in_acc;

    assign pos_ext      = {{CW{1'b0}}, i_position};
    assign pos1_ext     = pos_ext + PW'(1);
    assign cnt_pos      = {{sat_pkg::POS_W{1'b0}}, r_count};
    assign pos_ok       = pos_ext < cnt_pos;
    assign pos_has_next = pos1_ext < cnt_pos;
    assign max_ext      = {{CW{1'b0}}, i_max_entries};
    assign cnt_ext      = {{sat_pkg::CFG_W{1'b0}}, r_count};
    // capacity is min(max_entries, DEPTH)
    assign full         = (cnt_ext >= max_ext) || (r_count == CW'(DEPTH));
    assign k2_ext       = {1'b0, r_k} + (CW + 1)'(2);
    assign in_acc       = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_value      = r_value;
        n_rd         = r_rd;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_rd     = r_out_rd;
        n_out_cnt    = r_out_cnt;
        o_mem_we     = 1'b0;
        o_mem_wdata  = r_value;
        wr_idx       = r_k;
        rd_idx       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value = i_value;
                    n_rd    = '0;
                    unique case (sat_pkg::t_action'(i_action))
                        sat_pkg::ACT_INSERT: begin
                            if (full) begin
                                n_status = sat_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_k     = '0;
                                n_state = S_INS_PUT;
                            end else begin
                                // scan down from the top entry
                                rd_idx  = r_count - CW'(1);
                                n_k     = r_count;
                                n_state = S_INS_CMP;
                            end
                        end
                        sat_pkg::ACT_LOOKUP: begin
                            if (pos_ok) begin
                                rd_idx  = pos_ext[CW-1:0];
                                n_state = S_LK_WAIT;
                            end else begin
                                n_status = sat_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        sat_pkg::ACT_REMOVE: begin
                            if (!pos_ok) begin
                                n_status = sat_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end else if (pos_has_next) begin
                                rd_idx  = pos1_ext[CW-1:0];
                                n_k     = pos_ext[CW-1:0];
                                n_state = S_RM_MV;
                            end else begin
                                n_count  = r_count - CW'(1);
                                n_status = sat_pkg::ST_OK;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_status = sat_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                o_mem_we = 1'b1;
                if (i_mem_rdata >= r_value) begin
                    // entry k-1 moves up to k
                    o_mem_wdata = i_mem_rdata;
                    n_k         = r_k - CW'(1);
                    if (r_k == CW'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        rd_idx = r_k - CW'(2);
                    end
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = sat_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_INS_PUT: begin
                o_mem_we = 1'b1;
                n_count  = r_count + CW'(1);
                n_status = sat_pkg::ST_OK;
                n_state  = S_DONE;
            end
            S_RM_MV: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                if (k2_ext < {1'b0, r_count}) begin
                    rd_idx = k2_ext[CW-1:0];
                    n_k    = r_k + CW'(1);
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = sat_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_LK_WAIT: begin
                n_rd     = i_mem_rdata;
                n_status = sat_pkg::ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_rd     = r_rd;
                    n_out_cnt    = cnt_ext[sat_pkg::COUNT_OUT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_k          <= n_k;
        r_value      <= n_value;
        r_rd         <= n_rd;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_rd     <= n_out_rd;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_mem_waddr   = wr_idx[AW-1:0];
    assign o_mem_raddr   = rd_idx[AW-1:0];
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_rd;
    assign o_entry_count = r_out_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state != S_IDLE) && (r_state != S_DONE))
        else $error("store written outside an operation");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) && $past(i_rst_n) |->
            (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)))
        else $error("count moved by more than one");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH      = sat_pkg::DEPTH_DEFAULT;
    localparam int CLK_PERIOD = 10;
    localparam int PHASE_LEN  = 170;
    localparam int N_PHASES   = 10;
    // tail wait after the last result, longer than the longest insert
    localparam int TAIL_WAIT  = 2 * DEPTH + 8;
    // the block decodes only three actions; the spare code must answer out of range
    localparam logic [sat_pkg::ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        sat_pkg::t_status                  status;
        logic [sat_pkg::VALUE_W-1:0]       read_value;
        logic [sat_pkg::COUNT_OUT_W-1:0]   entry_count;
    } t_table_result;

    // Predicts each result from the accepted transactions and checks the
    // block's results against it, oldest first.
    class sorted_table_scoreboard;
        logic [sat_pkg::VALUE_W-1:0] stored[DEPTH];
        int                          stored_count;
        int                          cap_limit;
        t_table_result               expected_responses[$];
        int                          errors;
        int                          n_checked;
        int                          n_full;
        int                          n_range;
        int                          peak;

        function new();
            stored_count = 0;
            errors       = 0;
            n_checked    = 0;
            n_full       = 0;
            n_range      = 0;
            peak         = 0;
            set_capacity(sat_pkg::MAX_ENTRIES_RESET);
        endfunction

        function void set_capacity(logic [sat_pkg::CFG_W-1:0] max_entries);
            cap_limit = (max_entries > DEPTH) ? DEPTH : int'(max_entries);
        endfunction

        function void note_request(logic [sat_pkg::ACTION_W-1:0] act,
                                   logic [sat_pkg::VALUE_W-1:0] val,
                                   logic [sat_pkg::POS_W-1:0] pos);
            t_table_result r;
            int            slot;
            r.status     = sat_pkg::ST_RANGE;
            r.read_value = '0;
            case (act)
                sat_pkg::ACT_INSERT: begin
                    if (stored_count >= cap_limit) begin
                        r.status = sat_pkg::ST_FULL;
                    end else begin
                        // equal values: new one goes in front of them
                        slot = 0;
                        while (slot < stored_count && stored[slot] < val) slot++;
                        for (int k = stored_count; k > slot; k--) stored[k] = stored[k-1];
                        stored[slot] = val;
                        stored_count++;
                        r.status = sat_pkg::ST_OK;
                    end
                end
                sat_pkg::ACT_LOOKUP: begin
                    if (pos < stored_count) begin
                        r.read_value = stored[pos];
                        r.status     = sat_pkg::ST_OK;
                    end
                end
                sat_pkg::ACT_REMOVE: begin
                    if (pos < stored_count) begin
                        for (int k = pos; k + 1 < stored_count; k++) stored[k] = stored[k+1];
                        stored_count--;
                        r.status = sat_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
            r.entry_count = stored_count[sat_pkg::COUNT_OUT_W-1:0];
            if (r.status == sat_pkg::ST_FULL) n_full++;
            if (r.status == sat_pkg::ST_RANGE) n_range++;
            if (stored_count > peak) peak = stored_count;
            expected_responses.push_back(r);
        endfunction

        function void check_response(logic [sat_pkg::STATUS_W-1:0] status,
                                     logic [sat_pkg::VALUE_W-1:0] rd,
                                     logic [sat_pkg::COUNT_OUT_W-1:0] cnt);
            t_table_result want;
            if (expected_responses.size() == 0) begin
                $error("unexpected result: status %0d read_value %h entry_count %0d",
                       status, rd, cnt);
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            n_checked++;
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (rd !== want.read_value) begin
                $error("read_value mismatch: expected %h, actual %h", want.read_value, rd);
                errors++;
            end
            if (cnt !== want.entry_count) begin
                $error("entry_count mismatch: expected %0d, actual %0d",
                       want.entry_count, cnt);
                errors++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Stimulus-side signals, all at a known value from time zero
    // ---------------------------------------------------------------------
    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic [sat_pkg::ACTION_W-1:0]    in_action   = '0;
    logic [sat_pkg::VALUE_W-1:0]     in_value    = '0;
    logic [sat_pkg::POS_W-1:0]       in_position = '0;
    logic                            out_ready   = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [sat_pkg::CFG_W-1:0]       cfg_wdata   = '0;

    logic                            in_ready;
    logic                            out_valid;
    logic [sat_pkg::STATUS_W-1:0]    out_status;
    logic [sat_pkg::VALUE_W-1:0]     out_read_value;
    logic [sat_pkg::COUNT_OUT_W-1:0] out_entry_count;

    // when set, both sides run flat out: no sender gaps, no result stalls
    logic                            no_idle     = 1'b0;

    sorted_table_scoreboard sb;

    sorted_array_table #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (in_action),
        .i_value       (in_value),
        .i_position    (in_position),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (out_status),
        .o_read_value  (out_read_value),
        .o_entry_count (out_entry_count),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("FAIL sorted_array_table");
        $finish;
    end

    // Idle lengths: mostly none or short, the odd long one.
    function automatic int gap_length();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------------
    // Result side: check every accepted result, then pick the next ready.
    // Outputs are sampled at the edge, before the block's updates land.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int run;
        run = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_response(out_status, out_read_value, out_entry_count);
            if (no_idle) begin
                out_ready <= 1'b1;
                run = 0;
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 99) < 60) begin
                out_ready <= 1'b1;
                run = $urandom_range(0, 15);
            end else begin
                out_ready <= 1'b0;
                run = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
            end
        end
    end

    // One input transaction: optional gap, then hold valid until accepted.
    // Valid is left high on return so a back-to-back transaction needs no
    // second assignment in the same step.
    task automatic send_request(logic [sat_pkg::ACTION_W-1:0] act,
                                logic [sat_pkg::VALUE_W-1:0] val,
                                logic [sat_pkg::POS_W-1:0] pos);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_action   <= act;
        in_value    <= val;
        in_position <= pos;
        do @(posedge clk); while (!in_ready);
        sb.note_request(act, val, pos);
    endtask

    // Sender holds off until every outstanding result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_responses.size() != 0) @(posedge clk);
    endtask

    // max_entries is written only with the table idle.
    task automatic write_max_entries(logic [sat_pkg::CFG_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_capacity(v);
        cfg_we    <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    logic [sat_pkg::CFG_W-1:0] phase_caps[N_PHASES] = '{
        5'd16, 5'd31, 5'd1, 5'd8, 5'd16, 5'd20, 5'd2, 5'd12, 5'd0, 5'd16
    };

    initial begin : stimulus
        int                           sel;
        int                           ins_bias;
        int                           vr;
        int                           pr;
        int                           total;
        logic [sat_pkg::ACTION_W-1:0] act;
        logic [sat_pkg::VALUE_W-1:0]  val;
        logic [sat_pkg::POS_W-1:0]    pos;

        sb = new();
        total = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing to read or remove, spare action code
        send_request(sat_pkg::ACT_LOOKUP, '0, 4'd0);
        send_request(sat_pkg::ACT_REMOVE, '0, 4'd15);
        send_request(ACT_NOP, 32'hFFFF_FFFF, 4'd15);

        // value extremes and equal values (new one lands in front)
        send_request(sat_pkg::ACT_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_request(sat_pkg::ACT_INSERT, 32'h0000_0000, 4'd15);
        send_request(sat_pkg::ACT_INSERT, 32'h8000_0000, 4'd0);
        send_request(sat_pkg::ACT_INSERT, 32'h0000_0000, 4'd0);
        send_request(sat_pkg::ACT_INSERT, 32'h0000_0005, 4'd0);
        send_request(sat_pkg::ACT_INSERT, 32'h0000_0005, 4'd0);
        for (int p = 0; p < 6; p++)
            send_request(sat_pkg::ACT_LOOKUP, '0, p[sat_pkg::POS_W-1:0]);
        send_request(sat_pkg::ACT_LOOKUP, '0, 4'd6);
        send_request(sat_pkg::ACT_LOOKUP, '0, 4'd15);
        send_request(sat_pkg::ACT_REMOVE, '0, 4'd1);
        send_request(sat_pkg::ACT_REMOVE, '0, 4'd5);

        // zero capacity: every insert refused, the stored entries stay usable
        write_max_entries(5'd0);
        send_request(sat_pkg::ACT_INSERT, 32'h0000_0001, 4'd0);
        send_request(sat_pkg::ACT_REMOVE, '0, 4'd0);
        send_request(sat_pkg::ACT_LOOKUP, '0, 4'd3);

        // capacity dropped below the current count
        write_max_entries(5'd3);
        send_request(sat_pkg::ACT_INSERT, 32'h0000_0002, 4'd0);
        send_request(sat_pkg::ACT_LOOKUP, '0, 4'd3);
        total = 24;

        // Random phases: each runs under its own capacity setting, some fill
        // the table, some drain it. Positions mostly hit stored entries.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_max_entries(phase_caps[ph]);
            no_idle  <= (ph == 3);
            ins_bias = $urandom_range(35, 70);
            for (int n = 0; n < PHASE_LEN; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    act = ACT_NOP;
                else if (sel < ins_bias)
                    act = sat_pkg::ACT_INSERT;
                else if (sel < ins_bias + (100 - ins_bias) / 2)
                    act = sat_pkg::ACT_LOOKUP;
                else
                    act = sat_pkg::ACT_REMOVE;

                vr = $urandom_range(0, 99);
                if (vr < 40)
                    val = $urandom_range(0, 7);
                else if (vr < 50)
                    val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                else if (vr < 55)
                    val = 32'hFFFF_FFF8 + $urandom_range(0, 7);
                else
                    val = $urandom;

                if (sb.stored_count > 0 && $urandom_range(0, 99) < 85)
                    pr = $urandom_range(0, sb.stored_count - 1);
                else
                    pr = $urandom_range(0, 15);
                pos = pr[sat_pkg::POS_W-1:0];

                send_request(act, val, pos);
                total++;
            end
        end
        no_idle <= 1'b0;

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);

        if (sb.expected_responses.size() != 0) begin
            $error("%0d results never arrived", sb.expected_responses.size());
            sb.errors++;
        end

        $display("Ran %0d transactions over %0d capacity settings, %0d results checked.",
                 total, N_PHASES + 2, sb.n_checked);
        $display("Refused as full: %0d, out of range: %0d, peak occupancy: %0d.",
                 sb.n_full, sb.n_range, sb.peak);
        if (sb.errors == 0) begin
            $display("PASS sorted_array_table");
        end else begin
            $display("FAIL sorted_array_table");
        end
        $finish;
    end

endmodule
